// ----- hw/rtl/abd_pkg.sv -----
// Shared types, constants and field widths of the ADPCM block decoder.
`timescale 1ns / 1ps

package abd_pkg;

    // Field widths of the input and result items
    localparam int CH_W     = 3;
    localparam int POS_W    = 5;
    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int COEF_W   = 15;
    localparam int SAMPLE_W = 16;
    localparam int SCALE_W  = 16;
    localparam int IDXS_W   = 5;

    // Arithmetic widths
    localparam int PROD_W = COEF_W + SAMPLE_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int PRED_W = 20;
    localparam int RES_W  = NIB_W + SCALE_W + 1;
    localparam int SUM_W  = 22;
    localparam int COEF_SHIFT = 12;

    // Saturation limits at the width of the raw sum
    localparam logic signed [SUM_W-1:0] SAMPLE_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -SUM_W'(32768);

    // Block layout
    localparam logic [POS_W-1:0] SCALE_HI_POS   = POS_W'(0);
    localparam logic [POS_W-1:0] SCALE_LO_POS   = POS_W'(1);
    localparam logic [POS_W-1:0] FIRST_DATA_POS = POS_W'(2);
    localparam logic [POS_W-1:0] LAST_DATA_POS  = POS_W'(17);

    // Default channel count
    localparam int DEF_MAX_CHANNELS = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COEF  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_COEF = CFG_IDX_W'(1);

    // What an incoming byte means
    typedef enum logic [1:0] {
        KIND_DROP,
        KIND_SCALE_HI,
        KIND_SCALE_LO,
        KIND_DATA
    } t_in_kind;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_EMIT
    } t_abd_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take_in;
        logic load_hist;
        logic mul_first;
        logic mul_second;
        logic sum;
        logic emit;
    } t_abd_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_in_kind kind;
        logic     second;
        logic     out_free;
    } t_abd_status;

endpackage

// ----- hw/rtl/abd_ctrl.sv -----
// Controller state machine of the ADPCM block decoder.
`timescale 1ns / 1ps

module abd_ctrl
    import abd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_abd_status i_status,
    output logic        o_in_ready,
    output t_abd_cmd    o_cmd
);

    t_abd_state r_state;
    t_abd_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.take_in = i_in_valid;
                if (i_in_valid && (i_status.kind == KIND_DATA)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.load_hist = 1'b1;
                n_state         = ST_MUL_A;
            end
            ST_MUL_A: begin
                o_cmd.mul_first = 1'b1;
                n_state         = ST_MUL_B;
            end
            ST_MUL_B: begin
                o_cmd.mul_second = 1'b1;
                n_state          = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                // Wait for room in the output register
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.second ? ST_IDLE : ST_MUL_A;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/abd_datapath.sv -----
// Datapath of the ADPCM block decoder: history memory, predictor and output register.
`timescale 1ns / 1ps

module abd_datapath
    import abd_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_abd_cmd             i_cmd,
    output t_abd_status          o_status,
    input  logic [CH_W-1:0]      i_channel_number,
    input  logic [POS_W-1:0]     i_byte_position,
    input  logic [BYTE_W-1:0]    i_block_byte,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CH_W-1:0]      o_out_channel,
    output logic [SAMPLE_W-1:0]  o_pcm_sample,
    output logic [IDXS_W-1:0]    o_sample_index,
    output logic                 o_pair_last,
    output logic                 o_end_marked
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int EXT_W = ((IDX_W > CH_W) ? IDX_W : CH_W) + 1;
    localparam int HIST_W = 2 * SAMPLE_W;

    // Configuration and block state
    logic signed [COEF_W-1:0]  r_coef0;
    logic signed [COEF_W-1:0]  r_coef1;
    logic [SCALE_W-1:0]        r_scale;

    // Item being decoded
    logic [CH_W-1:0]           r_ch;
    logic [POS_W-1:0]          r_pos;
    logic [BYTE_W-1:0]         r_byte;
    logic                      r_second;

    // Working history and arithmetic
    logic signed [SAMPLE_W-1:0] r_last;
    logic signed [SAMPLE_W-1:0] r_older;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SUM_W-1:0]    r_sum;

    // History memory with a valid bit per channel
    logic [HIST_W-1:0]         hist_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]   r_hist_ok;

    logic [EXT_W-1:0]          in_ch_ext;
    logic [EXT_W-1:0]          cur_ch_ext;
    logic [IDX_W-1:0]          cur_idx;
    t_in_kind                  kind;

    logic signed [COEF_W-1:0]   mul_coef;
    logic signed [SAMPLE_W-1:0] mul_smp;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    acc_base;
    logic signed [PRED_W-1:0]   pred;
    logic signed [NIB_W-1:0]    resid;
    logic signed [RES_W-1:0]    res_prod;
    logic signed [SAMPLE_W-1:0] sat;

    // Classify the incoming byte
    assign in_ch_ext = EXT_W'(i_channel_number);
    always_comb begin
        kind = KIND_DROP;
        if (in_ch_ext < EXT_W'(MAX_CHANNELS)) begin
            if (i_byte_position == SCALE_HI_POS) begin
                kind = KIND_SCALE_HI;
            end else if (i_byte_position == SCALE_LO_POS) begin
                kind = KIND_SCALE_LO;
            end else if (i_byte_position inside {[FIRST_DATA_POS:LAST_DATA_POS]}) begin
                kind = KIND_DATA;
            end
        end
    end

    assign cur_ch_ext = EXT_W'(r_ch);
    assign cur_idx    = cur_ch_ext[IDX_W-1:0];

    // Shared predictor multiplier: c0*last first, then c1*older accumulated
    assign mul_coef = i_cmd.mul_second ? r_coef1 : r_coef0;
    assign mul_smp  = i_cmd.mul_second ? r_older : r_last;
    assign prod     = mul_coef * mul_smp;
    assign acc_base = i_cmd.mul_second ? r_acc : '0;

    // Floor division by 4096 and the scaled residual
    assign pred     = PRED_W'(r_acc >>> COEF_SHIFT);
    assign resid    = r_second ? r_byte[NIB_W-1:0] : r_byte[BYTE_W-1:NIB_W];
    assign res_prod = resid * $signed({1'b0, r_scale});

    // Saturate the raw sum to a 16-bit sample
    always_comb begin
        if (r_sum > SAMPLE_MAX) begin
            sat = SAMPLE_W'(SAMPLE_MAX);
        end else if (r_sum < SAMPLE_MIN) begin
            sat = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            sat = r_sum[SAMPLE_W-1:0];
        end
    end

    // Control registers: coefficients, scale, valid bits, output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef0     <= '0;
            r_coef1     <= '0;
            r_scale     <= '0;
            r_hist_ok   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_FIRST_COEF:  r_coef0 <= i_cfg_data;
                    REG_SECOND_COEF: r_coef1 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.take_in && (kind == KIND_SCALE_HI)) begin
                r_scale[SCALE_W-1:BYTE_W] <= i_block_byte;
            end
            if (i_cmd.take_in && (kind == KIND_SCALE_LO)) begin
                r_scale[BYTE_W-1:0] <= i_block_byte;
            end
            if (i_cmd.emit && r_second) begin
                r_hist_ok[cur_idx] <= 1'b1;
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // History memory: written once per data byte, read into the working history
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && r_second) begin
            hist_mem[cur_idx] <= {r_last, sat};
        end
    end

    // Payload registers of the working item
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_ch     <= i_channel_number;
            r_pos    <= i_byte_position;
            r_byte   <= i_block_byte;
            r_second <= 1'b0;
        end
        if (i_cmd.load_hist) begin
            if (r_hist_ok[cur_idx]) begin
                r_older <= hist_mem[cur_idx][HIST_W-1:SAMPLE_W];
                r_last  <= hist_mem[cur_idx][SAMPLE_W-1:0];
            end else begin
                r_older <= '0;
                r_last  <= '0;
            end
        end
        if (i_cmd.mul_first || i_cmd.mul_second) begin
            r_acc <= acc_base + ACC_W'(prod);
        end
        if (i_cmd.sum) begin
            r_sum <= SUM_W'(pred) + SUM_W'(res_prod);
        end
        if (i_cmd.emit) begin
            r_older        <= r_last;
            r_last         <= sat;
            r_second       <= ~r_second;
            o_out_channel  <= r_ch;
            o_pcm_sample   <= sat;
            o_sample_index <= {4'(r_pos - FIRST_DATA_POS), r_second};
            o_pair_last    <= r_second;
            o_end_marked   <= r_scale[SCALE_W-1];
        end
    end

    assign o_status.kind     = kind;
    assign o_status.second   = r_second;
    assign o_status.out_free = !o_out_valid || i_out_ready;

endmodule

// ----- hw/rtl/adpcm_block_decoder.sv -----
// Top level of the four-bit ADPCM block decoder.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Content
// s_axis    in         tvalid / tready              one block byte with channel and position
// m_axis    out        tvalid / tready              one decoded sample
// cfg       in         valid / ready                coefficient register write
//
// A scale byte or an ignored byte is taken in the idle state. A data byte is accepted,
// its channel history is read from the history memory, then each of its two samples
// takes c0*last and an accumulated c1*older on the shared predictor multiplier, an add
// of the scaled residual and a load of the output register. A stalled output holds the
// second sample back until the first has gone. Reset clears the coefficients, the
// scale and the per-channel history valid bits.

module adpcm_block_decoder
    import abd_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [2:0] channel_number, [7:3] byte_position, [15:8] block_byte
    input  logic [15:0]          i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [2:0] out_channel, [18:3] pcm_sample, [23:19] sample_index
    output logic [23:0]          o_m_axis_tdata,
    output logic                 o_m_axis_tlast,
    // [0] end_marked
    output logic                 o_m_axis_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    t_abd_cmd    cmd;
    t_abd_status status;

    logic [CH_W-1:0]     out_channel;
    logic [SAMPLE_W-1:0] pcm_sample;
    logic [IDXS_W-1:0]   sample_index;

    // Registers are always writable
    assign o_cfg_ready = 1'b1;

    abd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    abd_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_channel_number (i_s_axis_tdata[2:0]),
        .i_byte_position  (i_s_axis_tdata[7:3]),
        .i_block_byte     (i_s_axis_tdata[15:8]),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_m_axis_tvalid),
        .i_out_ready      (i_m_axis_tready),
        .o_out_channel    (out_channel),
        .o_pcm_sample     (pcm_sample),
        .o_sample_index   (sample_index),
        .o_pair_last      (o_m_axis_tlast),
        .o_end_marked     (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {sample_index, pcm_sample, out_channel};

    // A sample is loaded only when the output register is empty or draining
    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("sample loaded over a waiting output item");

    // A data byte blocks the input while its samples are worked out
    a_data_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (status.kind == KIND_DATA))
        |=> !o_s_axis_tready)
        else $error("input taken while a data byte is still being decoded");

    // After the second sample of a byte the decoder is ready again
    a_pair_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && status.second) |=> o_s_axis_tready)
        else $error("decoder not ready after the second sample of a byte");

    // The second sample of a byte leaves with the pair flag set
    a_pair_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> (o_m_axis_tlast == $past(status.second)))
        else $error("pair flag does not match the nibble decoded");

endmodule
